// ===== src/ccp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccp_pkg
// Types, constants and small constant tables for the condensation block.
// ----------------------------------------------------------------------------
package ccp_pkg;

    // field ranges
    localparam logic signed [23:0] T_MAX = 24'sd6553600;
    localparam logic signed [23:0] T_MIN = -24'sd6553600;

    // fixed-point coefficients
    localparam logic [20:0] COEF_A    = 21'd1155072;    // 17.625 in Q16
    localparam logic [24:0] OFFSET_B  = 25'd15927869;   // 243.04 in Q16
    localparam logic [31:0] LN2_Q32   = 32'd2977044472; // ln2 in Q32
    localparam logic [26:0] CAP_SCALE = 27'd102069932;  // 610.94*25/9.80665 in Q16
    localparam logic [27:0] HEAT_Q16  = 28'd159764378;  // 2450000/1005 in Q16

    // 2^48 / ln2_q32: estimate of k from the Q16 exponent
    localparam logic [16:0] K_RECIP = 17'((64'd1 << 48) / 64'd2977044472);

    localparam int DIV1_Q       = 21;  // quotient bits of the exponent divide
    localparam int DIV2_Q       = 32;  // quotient bits of the heating ratio
    localparam int TAYLOR_TERMS = 12;

    localparam logic [23:0] CONDENSE_RST = 24'd277303;
    localparam logic [23:0] RAIN_RST     = 24'd55831;
    localparam logic [46:0] THRESH_RST   = 47'd6553600;

    typedef enum logic [1:0] {
        CFG_CONDENSE = 2'd0,
        CFG_RAIN     = 2'd1,
        CFG_THRESH   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [23:0] temperature_in;
        logic [46:0]        dry_in;
        logic [46:0]        vapor_in;
        logic [46:0]        cloud_in;
    } ccp_in_t;

    typedef struct packed {
        logic signed [23:0] temperature_out;
        logic [46:0]        vapor_out;
        logic [46:0]        cloud_out;
    } ccp_out_t;

    // exact reciprocal for n/i with 32-bit n: q = (n * recip) >> shift
    function automatic logic [32:0] taylor_recip(input int i);
        logic [32:0] m;
        case (i)
            2:       m = 33'((64'd1 << 33) / 64'd2  + 64'd1);
            3:       m = 33'((64'd1 << 34) / 64'd3  + 64'd1);
            4:       m = 33'((64'd1 << 34) / 64'd4  + 64'd1);
            5:       m = 33'((64'd1 << 35) / 64'd5  + 64'd1);
            6:       m = 33'((64'd1 << 35) / 64'd6  + 64'd1);
            7:       m = 33'((64'd1 << 35) / 64'd7  + 64'd1);
            8:       m = 33'((64'd1 << 35) / 64'd8  + 64'd1);
            9:       m = 33'((64'd1 << 36) / 64'd9  + 64'd1);
            10:      m = 33'((64'd1 << 36) / 64'd10 + 64'd1);
            11:      m = 33'((64'd1 << 36) / 64'd11 + 64'd1);
            12:      m = 33'((64'd1 << 36) / 64'd12 + 64'd1);
            default: m = 33'd0;
        endcase
        return m;
    endfunction

    function automatic int taylor_shift(input int i);
        int s;
        case (i)
            2:       s = 33;
            3, 4:    s = 34;
            5, 6, 7, 8: s = 35;
            default: s = 36;
        endcase
        return s;
    endfunction

endpackage

// ===== src/cell_condensation_precipitation.sv =====
// ----------------------------------------------------------------------------
// cell_condensation_precipitation
// Saturation, condensation, latent heating and rain for one grid cell.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data take one cell per item (temperature Q8.16, dry,
//   vapor and cloud masses Q31.16). m_valid/m_ready/m_data return the
//   updated cell, one result item per input item, in order.
//   cfg_we/cfg_index/cfg_wdata write condense_fraction (0), rain_fraction (1)
//   and rain_threshold (2); index 3 is ignored. Write only while idle.
// Depth: set by the 21-stage exponent divider, the 11 two-stage Taylor
//   terms and the 32-stage restoring divider of the heating ratio.
// Throughput: one item per cycle while not stalled. Every stage is a
//   register that moves together; the output register is the last stage.
// Stall: while m_valid is high and m_ready low the whole pipeline holds and
//   s_ready is low; no item is dropped or repeated. Bubbles stay in place.
// Reset: aresetn (synchronous, active low) clears all valid bits and loads
//   the register reset values.
// ----------------------------------------------------------------------------
module cell_condensation_precipitation
    import ccp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ccp_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output ccp_out_t    m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [46:0] cfg_wdata
);

    typedef struct packed {
        ccp_in_t            item;
        logic signed [7:0]  k;
        logic [31:0]        r;
    } exp_ctx_t;

    typedef struct packed {
        logic signed [23:0] t;
        logic [46:0]        vapor;
        logic [47:0]        cloud;
        logic [47:0]        mass;
        logic               heat;
        logic               big;
    } heat_ctx_t;

    // global advance: the whole pipe moves when the output can take an item
    logic adv;
    logic o_v_reg;
    ccp_out_t o_data_reg;

    assign adv     = !o_v_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = o_v_reg;
    assign m_data  = o_data_reg;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [23:0] cfg_cond_reg;
    logic [23:0] cfg_rain_reg;
    logic [46:0] cfg_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_cond_reg <= CONDENSE_RST;
            cfg_rain_reg <= RAIN_RST;
            cfg_thr_reg  <= THRESH_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CONDENSE: cfg_cond_reg <= cfg_wdata[23:0];
                CFG_RAIN:     cfg_rain_reg <= cfg_wdata[23:0];
                CFG_THRESH:   cfg_thr_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // entry: T*A and T+B, sign split off for the magnitude divide
    // ------------------------------------------------------------------
    logic signed [45:0] a_num;
    logic [45:0]        a_mag;
    logic [25:0]        a_den;

    assign a_num = $signed(46'(s_data.temperature_in)) * $signed(46'({1'b0, COEF_A}));
    assign a_mag = a_num[45] ? 46'(-a_num) : a_num;
    assign a_den = 26'($signed(26'(s_data.temperature_in)) + $signed({1'b0, OFFSET_B}));

    logic        d1_v_reg    [0:DIV1_Q];
    logic [24:0] d1_rem_reg  [0:DIV1_Q];
    logic [20:0] d1_q_reg    [0:DIV1_Q];
    logic [20:0] d1_low_reg  [0:DIV1_Q];
    logic [24:0] d1_den_reg  [0:DIV1_Q];
    logic        d1_neg_reg  [0:DIV1_Q];
    ccp_in_t     d1_item_reg [0:DIV1_Q];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_v_reg[0] <= 1'b0;
        end else if (adv) begin
            d1_v_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_rem_reg[0]  <= 25'(a_mag[43:21]);
            d1_low_reg[0]  <= a_mag[20:0];
            d1_q_reg[0]    <= '0;
            d1_den_reg[0]  <= a_den[24:0];
            d1_neg_reg[0]  <= a_num[45];
            d1_item_reg[0] <= s_data;
        end
    end

    // ------------------------------------------------------------------
    // exponent divide: one quotient bit per stage
    // ------------------------------------------------------------------
    for (genvar j = 0; j < DIV1_Q; j++) begin : g_div1
        logic [25:0] trial;
        logic        ge;

        assign trial = {d1_rem_reg[j], d1_low_reg[j][DIV1_Q-1-j]};
        assign ge    = trial >= {1'b0, d1_den_reg[j]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d1_v_reg[j+1] <= 1'b0;
            end else if (adv) begin
                d1_v_reg[j+1] <= d1_v_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                d1_rem_reg[j+1]  <= ge ? 25'(trial - {1'b0, d1_den_reg[j]}) : trial[24:0];
                d1_q_reg[j+1]    <= {d1_q_reg[j][19:0], ge};
                d1_low_reg[j+1]  <= d1_low_reg[j];
                d1_den_reg[j+1]  <= d1_den_reg[j];
                d1_neg_reg[j+1]  <= d1_neg_reg[j];
                d1_item_reg[j+1] <= d1_item_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // range reduction x = k*ln2 + r
    // ------------------------------------------------------------------
    logic signed [21:0] k_xq;
    assign k_xq = d1_neg_reg[DIV1_Q] ? -$signed({1'b0, d1_q_reg[DIV1_Q]})
                                     :  $signed({1'b0, d1_q_reg[DIV1_Q]});

    logic               k1_v_reg;
    logic signed [39:0] k1_prod_reg;
    logic signed [21:0] k1_xq_reg;
    ccp_in_t            k1_item_reg;

    logic               k2_v_reg;
    logic signed [40:0] k2_kl_reg;
    logic signed [7:0]  k2_ke_reg;
    logic signed [37:0] k2_x32_reg;
    ccp_in_t            k2_item_reg;

    logic signed [7:0]  k_ke;
    logic signed [41:0] k_r0;
    logic signed [41:0] k_ln2;
    logic signed [7:0]  k_k;
    logic [31:0]        k_r;

    assign k_ke  = k1_prod_reg[39:32];
    assign k_ln2 = $signed({10'd0, LN2_Q32});
    assign k_r0  = $signed(42'(k2_x32_reg)) - $signed(42'(k2_kl_reg));

    always_comb begin
        if (k_r0 < 0) begin
            k_k = k2_ke_reg - 8'sd1;
            k_r = 32'(k_r0 + k_ln2);
        end else if (k_r0 >= k_ln2) begin
            k_k = k2_ke_reg + 8'sd1;
            k_r = 32'(k_r0 - k_ln2);
        end else begin
            k_k = k2_ke_reg;
            k_r = k_r0[31:0];
        end
    end

    // Taylor stages: index 1 holds term r, sum 1+r
    logic        tm_v_reg    [1:TAYLOR_TERMS];
    logic [31:0] tm_term_reg [1:TAYLOR_TERMS];
    logic [33:0] tm_sum_reg  [1:TAYLOR_TERMS];
    exp_ctx_t    tm_ctx_reg  [1:TAYLOR_TERMS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k1_v_reg    <= 1'b0;
            k2_v_reg    <= 1'b0;
            tm_v_reg[1] <= 1'b0;
        end else if (adv) begin
            k1_v_reg    <= d1_v_reg[DIV1_Q];
            k2_v_reg    <= k1_v_reg;
            tm_v_reg[1] <= k2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            k1_prod_reg <= $signed(40'(k_xq)) * $signed({23'd0, K_RECIP});
            k1_xq_reg   <= k_xq;
            k1_item_reg <= d1_item_reg[DIV1_Q];

            k2_kl_reg   <= $signed(41'(k_ke)) * $signed({9'd0, LN2_Q32});
            k2_ke_reg   <= k_ke;
            k2_x32_reg  <= {k1_xq_reg, 16'd0};
            k2_item_reg <= k1_item_reg;

            tm_term_reg[1]     <= k_r;
            tm_sum_reg[1]      <= (34'd1 << 32) + 34'(k_r);
            tm_ctx_reg[1].item <= k2_item_reg;
            tm_ctx_reg[1].k    <= k_k;
            tm_ctx_reg[1].r    <= k_r;
        end
    end

    // ------------------------------------------------------------------
    // exp(r): term_i = ((term*r) >> 32) / i, two stages per term
    // ------------------------------------------------------------------
    for (genvar i = 2; i <= TAYLOR_TERMS; i++) begin : g_taylor
        logic [63:0] mul;
        logic [31:0] tp_reg;
        logic [33:0] tp_sum_reg;
        exp_ctx_t    tp_ctx_reg;
        logic        tp_v_reg;
        logic [64:0] qp;
        logic [31:0] term;

        assign mul  = 64'(tm_term_reg[i-1]) * 64'(tm_ctx_reg[i-1].r);
        assign qp   = 65'(tp_reg) * 65'(taylor_recip(i));
        assign term = 32'(qp >> taylor_shift(i));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tp_v_reg    <= 1'b0;
                tm_v_reg[i] <= 1'b0;
            end else if (adv) begin
                tp_v_reg    <= tm_v_reg[i-1];
                tm_v_reg[i] <= tp_v_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                tp_reg         <= mul[63:32];
                tp_sum_reg     <= tm_sum_reg[i-1];
                tp_ctx_reg     <= tm_ctx_reg[i-1];
                tm_term_reg[i] <= term;
                tm_sum_reg[i]  <= tp_sum_reg + 34'(term);
                tm_ctx_reg[i]  <= tp_ctx_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // capacity = (scale * sum) >> (32 - k)
    // ------------------------------------------------------------------
    logic              c1_v_reg;
    logic [60:0]       c1_p_reg;
    exp_ctx_t          c1_ctx_reg;
    logic              c2_v_reg;
    logic [60:0]       c2_cap_reg;
    ccp_in_t           c2_item_reg;
    logic signed [8:0] c_sh;
    logic [60:0]       c_cap;

    assign c_sh = 9'sd32 - $signed(9'(c1_ctx_reg.k));

    always_comb begin
        if (c_sh >= 9'sd64) begin
            c_cap = '0;
        end else if (c_sh <= 9'sd0) begin
            c_cap = c1_p_reg;
        end else begin
            c_cap = c1_p_reg >> c_sh[5:0];
        end
    end

    // ------------------------------------------------------------------
    // condensation
    // ------------------------------------------------------------------
    logic        e1_v_reg, e2_v_reg, e3_v_reg;
    logic        e1_flag_reg, e2_flag_reg;
    logic [46:0] e1_exc_reg;
    logic [47:0] e1_mass_reg, e2_mass_reg, e3_mass_reg;
    ccp_in_t     e1_item_reg, e2_item_reg, e3_item_reg;
    logic [46:0] e2_hi_reg;
    logic [47:0] e2_lo_reg;
    logic [46:0] e3_cond_reg;
    logic        e3_flag_reg;
    logic        e_flag;

    assign e_flag = {14'd0, c2_item_reg.vapor_in} > c2_cap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_v_reg <= 1'b0;
            c2_v_reg <= 1'b0;
            e1_v_reg <= 1'b0;
            e2_v_reg <= 1'b0;
            e3_v_reg <= 1'b0;
        end else if (adv) begin
            c1_v_reg <= tm_v_reg[TAYLOR_TERMS];
            c2_v_reg <= c1_v_reg;
            e1_v_reg <= c2_v_reg;
            e2_v_reg <= e1_v_reg;
            e3_v_reg <= e2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_p_reg    <= 61'(tm_sum_reg[TAYLOR_TERMS]) * 61'(CAP_SCALE);
            c1_ctx_reg  <= tm_ctx_reg[TAYLOR_TERMS];
            c2_cap_reg  <= c_cap;
            c2_item_reg <= c1_ctx_reg.item;

            e1_flag_reg <= e_flag;
            e1_exc_reg  <= 47'(c2_item_reg.vapor_in - c2_cap_reg[46:0]);
            e1_mass_reg <= 48'(c2_item_reg.dry_in) + 48'(c2_item_reg.vapor_in);
            e1_item_reg <= c2_item_reg;

            e2_hi_reg   <= 47'(e1_exc_reg[46:24]) * 47'(cfg_cond_reg);
            e2_lo_reg   <= 48'(e1_exc_reg[23:0]) * 48'(cfg_cond_reg);
            e2_flag_reg <= e1_flag_reg;
            e2_mass_reg <= e1_mass_reg;
            e2_item_reg <= e1_item_reg;

            e3_cond_reg <= e2_flag_reg ? 47'(e2_hi_reg + 47'(e2_lo_reg >> 24)) : '0;
            e3_flag_reg <= e2_flag_reg;
            e3_mass_reg <= e2_mass_reg;
            e3_item_reg <= e2_item_reg;
        end
    end

    // ------------------------------------------------------------------
    // heating ratio condensed*2^32/mass, one bit per stage
    // ------------------------------------------------------------------
    logic        d2_v_reg   [0:DIV2_Q];
    logic [47:0] d2_rem_reg [0:DIV2_Q];
    logic [31:0] d2_q_reg   [0:DIV2_Q];
    heat_ctx_t   d2_ctx_reg [0:DIV2_Q];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d2_v_reg[0] <= 1'b0;
        end else if (adv) begin
            d2_v_reg[0] <= e3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d2_rem_reg[0]       <= 48'(e3_cond_reg);
            d2_q_reg[0]         <= '0;
            d2_ctx_reg[0].t     <= e3_item_reg.temperature_in;
            d2_ctx_reg[0].vapor <= e3_item_reg.vapor_in - e3_cond_reg;
            d2_ctx_reg[0].cloud <= 48'(e3_item_reg.cloud_in) + 48'(e3_cond_reg);
            d2_ctx_reg[0].mass  <= e3_mass_reg;
            d2_ctx_reg[0].heat  <= e3_flag_reg && (e3_mass_reg != '0);
            d2_ctx_reg[0].big   <= 48'(e3_cond_reg) >= e3_mass_reg;
        end
    end

    for (genvar j = 0; j < DIV2_Q; j++) begin : g_div2
        logic [48:0] trial;
        logic        ge;

        assign trial = {d2_rem_reg[j], 1'b0};
        assign ge    = trial >= {1'b0, d2_ctx_reg[j].mass};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d2_v_reg[j+1] <= 1'b0;
            end else if (adv) begin
                d2_v_reg[j+1] <= d2_v_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                d2_rem_reg[j+1] <= ge ? 48'(trial - {1'b0, d2_ctx_reg[j].mass}) : trial[47:0];
                d2_q_reg[j+1]   <= {d2_q_reg[j][30:0], ge};
                d2_ctx_reg[j+1] <= d2_ctx_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // temperature rise, rain, saturation
    // ------------------------------------------------------------------
    logic        h1_v_reg, h2_v_reg;
    logic [60:0] h1_prod_reg;
    heat_ctx_t   h1_ctx_reg, h2_ctx_reg;
    logic        h1_rain_reg, h2_rain_reg;
    logic [47:0] h1_rexc_reg;
    logic [47:0] h2_rhi_reg, h2_rlo_reg;
    logic signed [29:0] h2_t_reg;
    logic [32:0] h_qf;
    logic [28:0] h_rise;
    logic signed [29:0] h_t;
    logic signed [23:0] o_t;
    logic [47:0] o_cloud;

    assign h_qf   = d2_ctx_reg[DIV2_Q].big ? (33'd1 << 32) : {1'b0, d2_q_reg[DIV2_Q]};
    assign h_rise = h1_prod_reg[60:32];
    assign h_t    = h1_ctx_reg.heat ? $signed(30'(h1_ctx_reg.t)) + $signed({1'b0, h_rise})
                                    : $signed(30'(h1_ctx_reg.t));

    always_comb begin
        if (h2_t_reg > $signed(30'(T_MAX))) begin
            o_t = T_MAX;
        end else if (h2_t_reg < $signed(30'(T_MIN))) begin
            o_t = T_MIN;
        end else begin
            o_t = h2_t_reg[23:0];
        end
        o_cloud = h2_rain_reg ? h2_ctx_reg.cloud - (h2_rhi_reg + (h2_rlo_reg >> 24))
                              : h2_ctx_reg.cloud;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h1_v_reg <= 1'b0;
            h2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end else if (adv) begin
            h1_v_reg <= d2_v_reg[DIV2_Q];
            h2_v_reg <= h1_v_reg;
            o_v_reg  <= h2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            h1_prod_reg <= 61'(h_qf) * 61'(HEAT_Q16);
            h1_ctx_reg  <= d2_ctx_reg[DIV2_Q];
            h1_rain_reg <= d2_ctx_reg[DIV2_Q].cloud > {1'b0, cfg_thr_reg};
            h1_rexc_reg <= d2_ctx_reg[DIV2_Q].cloud - {1'b0, cfg_thr_reg};

            h2_t_reg    <= h_t;
            h2_ctx_reg  <= h1_ctx_reg;
            h2_rain_reg <= h1_rain_reg;
            h2_rhi_reg  <= 48'(h1_rexc_reg[47:24]) * 48'(cfg_rain_reg);
            h2_rlo_reg  <= 48'(h1_rexc_reg[23:0]) * 48'(cfg_rain_reg);

            o_data_reg.temperature_out <= o_t;
            o_data_reg.vapor_out       <= h2_ctx_reg.vapor;
            o_data_reg.cloud_out       <= o_cloud[47] ? {47{1'b1}} : o_cloud[46:0];
        end
    end

endmodule

// ===== src/ccp_checker.sv =====
// ----------------------------------------------------------------------------
// ccp_checker
// Port-level checks on the condensation block, bound to the top level.
// ----------------------------------------------------------------------------
module ccp_checker
    import ccp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input ccp_out_t    m_data
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result item valid right after reset");

    // an empty output register never holds back the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.temperature_out <= T_MAX) && (m_data.temperature_out >= T_MIN))
        else $error("temperature_out outside saturation range");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result item changed while stalled");

endmodule

bind cell_condensation_precipitation ccp_checker u_ccp_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cell_condensation_precipitation: a bit-exact
// predictor of capacity, condensation, heating and rain feeds an in-order
// store of expected cells; random bursts, gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    import ccp_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    ccp_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    ccp_out_t    m_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [46:0] cfg_wdata = '0;

    // predictor copy of the registers
    logic [23:0] cur_condense;
    logic [23:0] cur_rain;
    logic [46:0] cur_thresh;

    ccp_out_t cell_expected_q[$];
    int       n_mismatch = 0;
    bit       hold_off = 1'b0;   // long receiver stall request
    bit       rx_calm = 1'b0;    // receiver always ready

    cell_condensation_precipitation dut (.*);

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic logic [63:0] share_of(logic [63:0] m, logic [23:0] f);
        return (m >> 24) * f + (((m & 64'hFFFFFF) * f) >> 24);
    endfunction

    function automatic logic [63:0] sat_capacity(longint t);
        longint   den, xq, x32, k, sh;
        logic [63:0] r, term, sum, p;
        den = t + 64'sd15927869;
        xq  = (t * 64'sd1155072) / den;   // truncates toward zero
        x32 = xq * 65536;
        k   = x32 / 64'sd2977044472;
        if ((x32 % 64'sd2977044472) != 0 && x32 < 0) k--;
        r    = x32 - k * 64'sd2977044472;
        term = 64'd1 << 32;
        sum  = term;
        for (int i = 1; i <= 12; i++) begin
            term = ((term * r) >> 32) / i;
            sum += term;
        end
        p  = 64'd102069932 * sum;
        sh = 32 - k;
        if (sh >= 64) return 64'd0;
        if (sh <= 0) return p;
        return p >> sh;
    endfunction

    function automatic logic [63:0] heat_ratio(logic [63:0] n, logic [63:0] d);
        logic [63:0] rem, q;
        rem = n;
        q = '0;
        if (n >= d) return 64'd1 << 32;
        for (int i = 0; i < 32; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d) begin
                rem -= d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic ccp_out_t predict_cell(ccp_in_t c);
        longint      t;
        logic [63:0] vap, cld, cap, cond, mass, q;
        ccp_out_t    o;
        t   = longint'(c.temperature_in);
        vap = {17'd0, c.vapor_in};
        cld = {17'd0, c.cloud_in};
        cap = sat_capacity(t);
        if (vap > cap) begin
            cond = share_of(vap - cap, cur_condense);
            mass = {17'd0, c.dry_in} + vap;   // vapor before condensing
            vap -= cond;
            cld += cond;
            if (mass > 0) begin
                q = heat_ratio(cond, mass);
                t += longint'((q * 64'd159764378) >> 32);
            end
        end
        if (cld > {17'd0, cur_thresh})
            cld -= share_of(cld - {17'd0, cur_thresh}, cur_rain);
        if (t > 6553600) t = 6553600;
        if (t < -6553600) t = -6553600;
        if (cld > 64'h7FFFFFFFFFFF) cld = 64'h7FFFFFFFFFFF;
        o.temperature_out = t[23:0];
        o.vapor_out = vap[46:0];
        o.cloud_out = cld[46:0];
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // driving helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(cfg_idx_t idx, logic [46:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CONDENSE: cur_condense = val[23:0];
            CFG_RAIN:     cur_rain = val[23:0];
            CFG_THRESH:   cur_thresh = val;
            default: ;
        endcase
    endtask

    // the ignored index: no register changes
    task automatic write_unused(logic [46:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= 2'd3;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // offer one cell at a falling edge, hold it until accepted
    task automatic send_cell(ccp_in_t c);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cell_expected_q.push_back(predict_cell(c));
        // valid stays high; next send or idle lowers it at the falling edge
    endtask

    task automatic go_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // wait for every expected result, then the pipeline depth
    task automatic drain();
        go_idle();
        while (cell_expected_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [46:0] rand_mass();
        logic [46:0] m;
        case ($urandom_range(0, 5))
            0: m = 47'({$urandom(), $urandom()});
            1: m = 47'($urandom_range(0, 32'h7FFFFF));        // up to ~128
            2: m = 47'($urandom_range(0, 32'h3FFFFFF));       // up to ~1024
            3: m = 47'd0;
            4: m = {47{1'b1}} - 47'($urandom_range(0, 255));
            default: m = 47'({$urandom(), $urandom()} >> $urandom_range(0, 46));
        endcase
        return m;
    endfunction

    function automatic ccp_in_t rand_cell();
        ccp_in_t c;
        if ($urandom_range(0, 9) == 0)
            c.temperature_in = 24'($urandom());          // full 24-bit pattern
        else
            c.temperature_in = 24'($signed($urandom_range(0, 13107200)) - 6553600);
        c.dry_in = rand_mass();
        c.vapor_in = rand_mass();
        c.cloud_in = rand_mass();
        return c;
    endfunction

    // burst of n cells with random gaps between bursts
    task automatic send_random(int n);
        int left;
        left = n;
        while (left > 0) begin
            for (int b = $urandom_range(1, 20); b > 0 && left > 0; b--) begin
                send_cell(rand_cell());
                left--;
            end
            if ($urandom_range(0, 2) != 0) begin
                go_idle();
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver: own stall pattern, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_off)
            m_ready <= 1'b0;
        else if (rx_calm)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge aclk) begin
        if ((($urandom_range(0, 199)) == 0) && !hold_off) rx_calm <= ~rx_calm;
    end

    // checker: compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        ccp_out_t exp_c;
        if (aresetn && m_valid && m_ready) begin
            if (cell_expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result item %h", m_data);
            end else begin
                exp_c = cell_expected_q.pop_front();
                if (m_data !== exp_c) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch T exp %0d got %0d V exp %h got %h C exp %h got %h",
                                 exp_c.temperature_out, m_data.temperature_out,
                                 exp_c.vapor_out, m_data.vapor_out,
                                 exp_c.cloud_out, m_data.cloud_out);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        ccp_in_t c;
        // extremes of temperature with saturated vapor
        c = '{24'sd6553600, 47'd6553600, {47{1'b1}}, 47'd0};       send_cell(c);
        c = '{-24'sd6553600, 47'd6553600, 47'd655360, 47'd0};      send_cell(c);
        c = '{24'sh7FFFFF, 47'd1, 47'd100000000, 47'd1};           send_cell(c);
        c = '{24'sh800000, 47'd0, 47'd100000000, 47'd1};           send_cell(c);
        c = '{24'sd0, 47'd0, 47'd0, 47'd0};                        send_cell(c);
        // no gas mass: dry+vapor zero, nothing to heat
        c = '{24'sd1310720, 47'd0, 47'd0, {47{1'b1}}};             send_cell(c);
        // all ones masses: cloud clamps
        c = '{24'sd0, {47{1'b1}}, {47{1'b1}}, {47{1'b1}}};         send_cell(c);
        // vapor well below capacity near 20 C
        c = '{24'sd1310720, 47'd65536000, 47'd10000000, 47'd5000000}; send_cell(c);
        c = '{24'sd1310720, 47'd65536000, 47'd100, 47'd7000000};   send_cell(c);
        // large heating, clamps high
        c = '{24'sd6000000, 47'd1, {47{1'b1}}, 47'd0};             send_cell(c);
        // input temperatures outside range, no condensation
        c = '{24'sd7000000, 47'd5, 47'd0, 47'd0};                  send_cell(c);
        c = '{-24'sd7000000, 47'd5, 47'd0, 47'd0};                 send_cell(c);
        // cloud at and just over threshold
        c = '{24'sd0, 47'd100, 47'd0, 47'd6553600};                send_cell(c);
        c = '{24'sd0, 47'd100, 47'd0, 47'd6553601};                send_cell(c);
        drain();
    endtask

    task automatic test_registers();
        // extremes of every register
        write_reg(CFG_CONDENSE, 47'hFFFFFF);
        write_reg(CFG_RAIN, 47'hFFFFFF);
        write_reg(CFG_THRESH, 47'd0);
        write_unused({47{1'b1}});
        send_random(150);
        drain();
        write_reg(CFG_CONDENSE, 47'd0);
        write_reg(CFG_RAIN, 47'd0);
        write_reg(CFG_THRESH, {47{1'b1}});
        send_random(150);
        drain();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_CONDENSE, 47'($urandom_range(0, 24'hFFFFFF)));
            write_reg(CFG_RAIN, 47'($urandom_range(0, 24'hFFFFFF)));
            write_reg(CFG_THRESH, 47'({$urandom(), $urandom()} >> $urandom_range(0, 30)));
            send_random(200);
            drain();
        end
    endtask

    // receiver holds off long enough to fill the pipeline and stall input
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            send_random(150);
        join
        drain();   // sender pauses until every result has come
        write_reg(CFG_CONDENSE, 47'(CONDENSE_RST));
        write_reg(CFG_RAIN, 47'(RAIN_RST));
        write_reg(CFG_THRESH, THRESH_RST);
        send_random(150);
        drain();
    endtask

    initial begin
        cur_condense = CONDENSE_RST;
        cur_rain = RAIN_RST;
        cur_thresh = THRESH_RST;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_registers();
        test_random_settings();
        test_backpressure();
        if (n_mismatch == 0 && cell_expected_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
src/ccp_pkg.sv
src/cell_condensation_precipitation.sv
src/ccp_checker.sv
test/tb.sv
